FILE: hw/rtl/rbo_pkg.sv
// Shared types, constants and channel arithmetic for the RGBA over-blend block.
`timescale 1ns / 1ps
`default_nettype none

package rbo_pkg;

  localparam int unsigned ChWidth  = 8;
  localparam int unsigned PixWidth = 4 * ChWidth;

  typedef logic [ChWidth-1:0]  chan_t;
  typedef logic [PixWidth-1:0] pixel_t;
  typedef logic [15:0]         prod_t;

  // blend_mode codes
  localparam logic MODE_COPY = 1'b0;
  localparam logic MODE_OVER = 1'b1;

  localparam chan_t CH_MAX     = 8'hFF;
  localparam chan_t CH_ZERO    = 8'h00;
  localparam prod_t ROUND_HALF = 16'd127;

  // Exact x / 255 for 16-bit x up to 65279, where the quotient fits 8 bits: q = (t + (t >> 8)) >> 8 with t = x + 1.
  function automatic chan_t div255(input prod_t x);
    logic [16:0] t;
    logic [16:0] s;
    t = {1'b0, x} + 17'd1;
    s = t + {8'd0, t[16:8]};
    return s[15:8];
  endfunction

  // (s*a + d*(255-a) + 127) / 255, never above 255.
  // Operands widen to 16 bits before the multiply so the full product is kept.
  function automatic chan_t mix_ch(input chan_t s, input chan_t d, input chan_t a);
    prod_t ps;
    prod_t pd;
    prod_t sum;
    ps  = prod_t'(s) * prod_t'(a);
    pd  = prod_t'(d) * prod_t'(CH_MAX - a);
    sum = ps + pd + ROUND_HALF;
    return div255(sum);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rbo_blend_core.sv
// Combinational compositing of one pixel word: source copy, or source over destination.
`timescale 1ns / 1ps
`default_nettype none

module rbo_blend_core import rbo_pkg::*; (
  input  wire logic   mode,
  input  wire pixel_t src,
  input  wire pixel_t dst,
  output pixel_t      pix
);

  chan_t       a;
  chan_t       d_a;
  chan_t       add_a;
  logic  [8:0] sum_a;
  pixel_t      mixed;

  assign a     = src[31:24];
  assign d_a   = dst[31:24];
  // d_a*(255-a) + 127, divided by 255
  assign add_a = div255(prod_t'(d_a) * prod_t'(CH_MAX - a) + ROUND_HALF);
  assign sum_a = {1'b0, a} + {1'b0, add_a};

  always_comb begin
    mixed[31:24] = sum_a[8] ? CH_MAX : sum_a[7:0];
    for (int k = 0; k < 3; k++) begin
      mixed[k*ChWidth +: ChWidth] = mix_ch(src[k*ChWidth +: ChWidth],
                                           dst[k*ChWidth +: ChWidth], a);
    end
  end

  always_comb begin
    if (mode == MODE_COPY) begin
      pix = src;
    end else if (a == CH_MAX) begin
      pix = src;
    end else if (a == CH_ZERO) begin
      pix = dst;
    end else begin
      pix = mixed;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rgba_blend_over_pixel.sv
// Top level of the RGBA over-blend block: input register, blend logic, result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Word
// -------   ---------------------  ----------------------------------------
// in        in_valid / in_ready    in_src_pixel[31:0], in_dst_pixel[31:0]
// out       out_valid / out_ready  out_pixel[31:0]
// cfg       cfg_we (no wait)       cfg_wdata = blend_mode (0 copy, 1 over)
//
// One word per cycle sustained while out_ready is high; an accepted word passes
// the input register, then the result register after the blend logic, to out_valid.
// Throughput is set by the single blend pass between the two registers.
// rst_n is synchronous, active low: both stages empty, blend_mode = copy.
// A stall on out_ready holds the result register; the input register still
// takes a word while the result register is occupied, and holds it until
// the result register frees up. in_ready follows out_ready combinationally.
// blend_mode is read as words pass the blend logic; write it only when idle.

module rgba_blend_over_pixel import rbo_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   cfg_we,
  input  wire logic   cfg_wdata,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire pixel_t in_src_pixel,
  input  wire pixel_t in_dst_pixel,
  output logic        out_valid,
  input  wire logic   out_ready,
  output pixel_t      out_pixel
);

  logic   mode_r;
  logic   s1_valid_r;
  pixel_t s1_src_r;
  pixel_t s1_dst_r;
  logic   s2_valid_r;
  pixel_t s2_pix_r;

  logic   s2_load;   // result register takes the blended word
  logic   s1_load;   // input register takes a new word
  logic   s1_valid_nxt;
  logic   s2_valid_nxt;
  pixel_t blend_pix;

  // Result register is free when empty or being drained this cycle.
  assign s2_load  = s1_valid_r && (!s2_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_load;
  assign s1_load  = in_valid && in_ready;

  assign s1_valid_nxt = s1_load || (s1_valid_r && !s2_load);
  assign s2_valid_nxt = s2_load || (s2_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_COPY;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_src_r <= in_src_pixel;
      s1_dst_r <= in_dst_pixel;
    end
    if (s2_load) begin
      s2_pix_r <= blend_pix;
    end
  end

  rbo_blend_core u_core (
    .mode (mode_r),
    .src  (s1_src_r),
    .dst  (s1_dst_r),
    .pix  (blend_pix)
  );

  assign out_valid = s2_valid_r;
  assign out_pixel = s2_pix_r;

  // An accepted word always lands in the input register.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load |=> s1_valid_r && s1_src_r == $past(in_src_pixel))
    else $error("accepted word not captured in input register");

  // A word waiting in the input register is held until it moves on.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_load |=> s1_valid_r && $stable(s1_src_r) && $stable(s1_dst_r))
    else $error("input register word lost or changed while stalled");

  // Empty input register always takes a word.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("in_ready low with empty input register");

  // Copy mode passes the source word through unchanged.
  a_copy_pass: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load && mode_r == MODE_COPY |=> out_valid && out_pixel == $past(s1_src_r))
    else $error("copy mode altered the source word");

  // Held result is not overwritten while out_ready is low.
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !out_ready |-> !s2_load)
    else $error("result register loaded while stalled");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the RGBA over-blend pixel block.
`timescale 1ns / 1ps

module tb_top;
  import rbo_pkg::*;

  // Blend arithmetic constants
  localparam int unsigned FULL_ALPHA = 255;
  localparam int unsigned HALF_UP    = 127;

  // Receiver hold-off length for the back-pressure test, in cycles
  localparam int HOLD_CYCLES = 300;
  // Cycles to wait after the last result before a mode write or the end
  localparam int SETTLE_CYCLES = 6;
  // Only this many mismatch lines get printed; all are counted
  localparam int MAX_PRINTED = 40;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   cfg_we;
  logic   cfg_wdata;
  logic   in_valid;
  logic   in_ready;
  pixel_t in_src_pixel;
  pixel_t in_dst_pixel;
  logic   out_valid;
  logic   out_ready;
  pixel_t out_pixel;

  // Expected composited pixels, oldest first
  pixel_t expected_pixels[$];
  // Mode as the block should hold it
  logic   blend_mode_q;

  int  err_count;
  int  words_sent;
  int  words_checked;
  int  mode_writes;
  bit  idle_on;       // random gaps on both sides while set
  bit  hold_request;  // asks the receiver for one long hold-off

  rgba_blend_over_pixel dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_src_pixel (in_src_pixel),
    .in_dst_pixel (in_dst_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel    (out_pixel)
  );

  always #6 clk = ~clk;

  // Expected pixel for one source/destination pair under a given mode.
  // Copy mode passes the source; over mode short-cuts opaque and clear
  // sources, otherwise blends each color channel with rounding and
  // accumulates alpha with saturation.
  function automatic pixel_t blend_predict(input logic mode, input pixel_t s,
                                           input pixel_t d);
    int unsigned a;
    int unsigned c;
    int unsigned oa;
    pixel_t      r;
    if (mode == MODE_COPY) return s;
    a = s[31:24];
    if (a == FULL_ALPHA) return s;
    if (a == 0) return d;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      c = (s[8*k +: 8] * a + d[8*k +: 8] * (FULL_ALPHA - a) + HALF_UP) / FULL_ALPHA;
      r[8*k +: 8] = c[7:0];
    end
    oa = a + (d[31:24] * (FULL_ALPHA - a) + HALF_UP) / FULL_ALPHA;
    if (oa > FULL_ALPHA) oa = FULL_ALPHA;
    r[31:24] = oa[7:0];
    return r;
  endfunction

  // Source pixel with alpha skewed toward the opaque/clear short-cuts
  // and the values next to them.
  function automatic pixel_t rand_src_pixel();
    pixel_t p;
    p = $urandom;
    case ($urandom_range(0, 9))
      0: p[31:24] = 8'h00;
      1: p[31:24] = 8'hFF;
      2: p[31:24] = 8'(($urandom_range(0, 1) != 0) ? 8'h01 : 8'hFE);
      default: ;
    endcase
    return p;
  endfunction

  task automatic report_mismatch(input string what, input pixel_t got,
                                 input pixel_t want);
    if (err_count < MAX_PRINTED)
      $display("tb_top: MISMATCH %s got %08h want %08h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // Send one word: optional random gap, then hold valid until accepted.
  // The expectation is queued at the accepting edge with the current mode.
  task automatic send_word(input pixel_t s, input pixel_t d);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_src_pixel <= s;
    in_dst_pixel <= d;
    do @(posedge clk); while (!in_ready);
    expected_pixels.push_back(blend_predict(blend_mode_q, s, d));
    words_sent++;
  endtask

  // Drop valid and wait for every expected word, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mode writes only land with the block empty.
  task automatic set_blend_mode(input logic mode);
    drain();
    cfg_wdata <= mode;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we       <= 1'b0;
    blend_mode_q  = mode;
    mode_writes++;
  endtask

  // Copy mode straight out of reset, then written explicitly.
  task automatic test_copy_directed();
    send_word(32'h0000_0000, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'h0000_0000);
    send_word(32'h00AB_CDEF, 32'h1234_5678);
    set_blend_mode(MODE_COPY);
    send_word(32'h80FF_00FF, 32'hFF00_FF00);
    send_word(32'h7F55_AA55, 32'hAAAA_AAAA);
    drain();
  endtask

  // Over mode: short-cuts, alpha edges, channel extremes, alpha saturation.
  task automatic test_over_directed();
    set_blend_mode(MODE_OVER);
    send_word(32'hFF12_3456, 32'h89AB_CDEF);  // opaque source passes
    send_word(32'h0012_3456, 32'h89AB_CDEF);  // clear source keeps dest
    send_word(32'h00FF_FFFF, 32'h0000_0000);
    send_word(32'h01FF_FFFF, 32'hFF00_0000);  // faint source, full dest alpha
    send_word(32'hFE00_0000, 32'hFFFF_FFFF);
    send_word(32'h80FF_FFFF, 32'h8000_0000);
    send_word(32'h8000_0000, 32'h80FF_FFFF);
    send_word(32'h7FFF_00FF, 32'h7F00_FF00);
    send_word(32'h01FF_FFFF, 32'h00FF_FFFF);
    send_word(32'hFE00_0000, 32'h0000_0000);
    send_word(32'h40FF_FFFF, 32'hFFFF_FFFF);  // alpha sum at the ceiling
    send_word(32'hC000_0000, 32'hFF00_0000);
    send_word(32'h55AA_55AA, 32'hAA55_AA55);
    send_word(32'hAA55_AA55, 32'h55AA_55AA);
    send_word(32'h0101_0101, 32'hFEFE_FEFE);
    send_word(32'hFEFE_FEFE, 32'h0101_0101);
    drain();
  endtask

  task automatic test_random_over(input int count);
    set_blend_mode(MODE_OVER);
    repeat (count) send_word(rand_src_pixel(), $urandom);
    drain();
  endtask

  task automatic test_random_copy(input int count);
    set_blend_mode(MODE_COPY);
    repeat (count) send_word(rand_src_pixel(), $urandom);
    drain();
  endtask

  // Flip the mode between short bursts, always from an empty block.
  task automatic test_mode_switch(input int bursts);
    for (int b = 0; b < bursts; b++) begin
      set_blend_mode((b % 2 == 0) ? MODE_OVER : MODE_COPY);
      repeat ($urandom_range(8, 40)) send_word(rand_src_pixel(), $urandom);
    end
    drain();
  endtask

  // Receiver holds off for a long stretch; the block fills and stalls input.
  task automatic test_backpressure(input int count);
    set_blend_mode(MODE_OVER);
    hold_request = 1'b1;
    repeat (count) send_word(rand_src_pixel(), $urandom);
    drain();
  endtask

  // No gaps on either side: full-rate streaming.
  task automatic test_full_rate(input int count);
    idle_on = 1'b0;
    set_blend_mode(MODE_OVER);
    repeat (count) send_word(rand_src_pixel(), $urandom);
    drain();
  endtask

  // Receiver: random stall bursts, calm stretches, and one long hold-off
  initial begin
    int stall_left;
    int calm_left;
    int hold_left;
    stall_left = 0;
    calm_left  = 0;
    hold_left  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (calm_left > 0 || !idle_on) begin
        if (calm_left > 0) calm_left--;
        out_ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 15))
          0: begin
            stall_left = $urandom_range(1, 16) - 1;
            out_ready <= 1'b0;
          end
          1: begin
            calm_left = $urandom_range(16, 64);
            out_ready <= 1'b1;
          end
          default: out_ready <= 1'b1;
        endcase
      end
    end
  end

  // Result checker, sampled on the edge so values are pre-update
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected word", out_pixel, '0);
      end else begin
        pixel_t want;
        want = expected_pixels.pop_front();
        if (out_pixel !== want) report_mismatch("out_pixel", out_pixel, want);
        words_checked++;
      end
    end
  end

  // Main sequence
  initial begin
    err_count     = 0;
    words_sent    = 0;
    words_checked = 0;
    mode_writes   = 0;
    idle_on       = 1'b1;
    hold_request  = 1'b0;
    blend_mode_q  = MODE_COPY;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= MODE_COPY;
    in_valid     <= 1'b0;
    in_src_pixel <= '0;
    in_dst_pixel <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_copy_directed();
    test_over_directed();
    test_random_over(600);
    test_backpressure(60);
    test_mode_switch(16);
    test_random_copy(150);
    test_full_rate(300);

    $display("tb_top: %0d words sent, %0d checked, %0d mode writes",
             words_sent, words_checked, mode_writes);
    $display("tb_top: covered copy/over modes, alpha short-cuts, stalls, full rate");
    if (err_count == 0 && expected_pixels.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("tb_top: timeout, %0d words still expected", expected_pixels.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/rbo_pkg.sv
hw/rtl/rbo_blend_core.sv
hw/rtl/rgba_blend_over_pixel.sv
sim/tb_top.sv
